>>> rtl/core/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
// Used by every module under rtl/core; depends on nothing.
package lbs_pkg;

   localparam int unsigned ElemsPerBone = 12;
   localparam int unsigned AccWidth     = 48;
   localparam logic        KindPalette  = 1'b0;
   localparam logic        KindInfluence = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [5:0]         bone;
      logic [3:0]         matrix_element;
      logic signed [31:0] matrix_value;
      logic [15:0]        vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last_influence;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_index;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   // Classified influence passed from the front end to the back end
   typedef struct packed {
      logic               bone_ok;
      logic [5:0]         bone;
      logic [15:0]        vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last_influence;
   } job_type;

endpackage

>>> rtl/core/lbs_front.sv
// Front end: accepts transactions, performs palette writes, queues influences.
// Depends on lbs_pkg.
module lbs_front
   import lbs_pkg::*;
#(
   parameter int unsigned NUM_BONES = 64,
   parameter int unsigned AddrWidth = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic                 back_busy,
   output logic                 pal_we,
   output logic [AddrWidth-1:0] pal_waddr,
   output logic signed [31:0]   pal_wdata,
   output logic                 job_valid,
   input  logic                 job_take,
   output job_type              job_data
);

   localparam int unsigned Depth = 4;

   job_type    q_ff [Depth];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       acc;
   logic       push;
   logic       bone_ok;
   job_type    job_new;

   // A palette write waits until no influence is queued or in progress
   assign req_stall = (cnt_ff == 3'(Depth))
                      || (req_data.kind == KindPalette && (cnt_ff != '0 || back_busy));
   assign acc       = req_valid && !req_stall;
   assign bone_ok   = 32'(req_data.bone) < NUM_BONES;

   // Palette writes go straight to the store
   assign pal_we    = acc && req_data.kind == KindPalette && bone_ok
                      && 32'(req_data.matrix_element) < ElemsPerBone;
   assign pal_waddr = AddrWidth'(32'(req_data.bone) * ElemsPerBone
                      + 32'(req_data.matrix_element));
   assign pal_wdata = req_data.matrix_value;

   assign push = acc && req_data.kind == KindInfluence;

   always_comb begin
      job_new.bone_ok        = bone_ok;
      job_new.bone           = req_data.bone;
      job_new.vertex_index   = req_data.vertex_index;
      job_new.pos_x          = req_data.pos_x;
      job_new.pos_y          = req_data.pos_y;
      job_new.pos_z          = req_data.pos_z;
      job_new.weight         = req_data.weight;
      job_new.last_influence = req_data.last_influence;
   end

   // Influence queue pointers
   always_comb begin
      wr_in  = wr_ff + 2'(push);
      rd_in  = rd_ff + 2'(job_take);
      cnt_in = cnt_ff + 3'(push) - 3'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= job_new;
   end

   assign job_valid = cnt_ff != '0;
   assign job_data  = q_ff[rd_ff];

endmodule

>>> rtl/core/lbs_back.sv
// Back end: per-influence sequencer with one shared 33x33 multiplier,
// accumulators and a result register. Depends on lbs_pkg.
module lbs_back
   import lbs_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned AddrWidth = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_take,
   input  job_type              job_data,
   output logic                 busy,
   output logic [AddrWidth-1:0] pal_raddr,
   input  logic signed [31:0]   pal_rdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMul  = 3'd1;
   localparam logic [2:0] StSum  = 3'd2;
   localparam logic [2:0] StWgt  = 3'd3;
   localparam logic [2:0] StWgh  = 3'd4;
   localparam logic [2:0] StCon  = 3'd5;
   localparam logic [2:0] StAcc  = 3'd6;
   localparam logic [2:0] StOut  = 3'd7;

   localparam int unsigned PW = 66;
   localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

   logic [2:0]  st_ff, st_in;
   logic [1:0]  col_ff, col_in;     // output column
   logic [1:0]  row_ff, row_in;     // matrix row 0..3
   logic        rdv_ff;             // palette read data valid
   logic        first_ff, first_in;
   job_type     job_ff;
   logic [16:0] w_ff;
   logic signed [PW-1:0]       sum_ff, sum_in;      // sum of x*m products
   logic signed [AccWidth-1:0] t_ff;
   logic [AccWidth-1:0]        tmag;                // |t|
   logic signed [31:0]         tr_ff;               // translation element
   logic signed [AccWidth-1:0] acc_ff [3];
   logic signed [AccWidth-1:0] cont_ff;
   logic signed [65:0]         prod;
   logic [39:0]                prod_ff;             // weight partial product
   logic [40:0]                plo_ff;              // low partial product, rounded
   logic signed [32:0]         ma, mb;
   logic                       wneg_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign busy = st_ff != StIdle;

   // Palette read address
   assign pal_raddr = AddrWidth'(32'(job_ff.bone) * ElemsPerBone
                      + 32'(row_ff) * 3 + 32'(col_ff));

   assign tmag = t_ff[AccWidth-1] ? AccWidth'(-t_ff) : AccWidth'(t_ff);

   // Shared multiplier operands; weight product is split into two 24-bit halves
   logic signed [31:0] pos_sel;
   logic signed [31:0] mval;
   always_comb begin
      unique case (row_ff)
         2'd0:    pos_sel = job_ff.pos_x;
         2'd1:    pos_sel = job_ff.pos_y;
         default: pos_sel = job_ff.pos_z;
      endcase
      mval = job_ff.bone_ok ? pal_rdata : '0;
      unique case (st_ff)
         StWgt: begin
            ma = {9'b0, tmag[23:0]};
            mb = {16'b0, w_ff};
         end
         StWgh: begin
            ma = {9'b0, tmag[47:24]};
            mb = {16'b0, w_ff};
         end
         default: begin
            ma = {pos_sel[31], pos_sel};
            mb = {mval[31], mval};
         end
      endcase
   end

   assign prod = ma * mb;

   // Rounded, saturated transform result
   logic signed [PW-1:0] rnd;
   logic signed [PW-1:0] tsum;
   always_comb begin
      rnd  = (sum_ff + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      tsum = rnd + PW'(tr_ff);
   end

   // Weighted magnitude, rounded; accumulator update
   logic [63:0] wsum;
   logic [AccWidth-1:0] mag;
   logic signed [AccWidth-1:0] accbase;
   logic signed [AccWidth:0] accsum;
   logic [1:0] ai;
   assign ai = col_ff;
   always_comb begin
      wsum    = (64'(prod_ff) << 24) + 64'(plo_ff);
      mag     = wsum[AccWidth+15:16];
      accbase = first_ff ? '0 : acc_ff[ai];
      accsum  = (AccWidth+1)'(accbase) + (AccWidth+1)'(cont_ff);
   end

   always_comb begin
      st_in    = st_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      sum_in   = sum_ff;
      first_in = first_ff;
      job_take = 1'b0;
      unique case (st_ff)
         StIdle: begin
            if (job_valid) begin
               job_take = 1'b1;
               st_in    = StMul;
               col_in   = '0;
               row_in   = '0;
               sum_in   = '0;
            end
         end
         StMul: begin
            // read addressed in previous cycle arrives when rdv_ff
            if (rdv_ff) begin
               if (row_ff == 2'd3) st_in = StSum;
               else begin
                  row_in = row_ff + 2'd1;
                  sum_in = sum_ff + prod;
               end
            end
         end
         StSum:  st_in = StWgt;
         StWgt:  st_in = StWgh;
         StWgh:  st_in = StCon;
         StCon:  st_in = StAcc;
         StAcc: begin
            if (col_ff == 2'd2) begin
               st_in    = StOut;
               first_in = job_ff.last_influence;
            end else begin
               col_in = col_ff + 2'd1;
               row_in = '0;
               sum_in = '0;
               st_in  = StMul;
            end
         end
         StOut: begin
            if (!job_ff.last_influence || !rsp_valid_ff || !rsp_stall) st_in = StIdle;
         end
         default: st_in = StIdle;
      endcase
   end

   // Result valid: cleared when taken, set when a new vertex is presented
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (st_ff == StOut && job_ff.last_influence && (!rsp_valid_ff || !rsp_stall))
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= StIdle;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         rdv_ff       <= 1'b0;
      end else begin
         st_ff        <= st_in;
         first_ff     <= first_in;
         col_ff       <= col_in;
         // a row advance re-addresses, so the registered palette read is not yet valid
         rdv_ff       <= (st_in == StMul) && (row_in == row_ff) && (st_ff == StMul) && !rdv_ff;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   logic signed [31:0] sat [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (acc_ff[i] > AccWidth'(64'sd2147483647)) sat[i] = 32'h7fffffff;
         else if (acc_ff[i] < -AccWidth'(64'sd2147483648)) sat[i] = 32'h80000000;
         else sat[i] = acc_ff[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
      end else if (st_ff == StAcc) begin
         if (accsum > (AccWidth+1)'(AccMax)) acc_ff[ai] <= AccMax;
         else if (accsum < (AccWidth+1)'(AccMin)) acc_ff[ai] <= AccMin;
         else acc_ff[ai] <= accsum[AccWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         job_ff <= job_data;
         w_ff   <= (job_data.weight > 17'd65536) ? 17'd65536 : job_data.weight;
      end
      sum_ff  <= sum_in;
      prod_ff <= prod[39:0];
      if (st_ff == StMul && rdv_ff && row_ff == 2'd3) tr_ff <= mval;
      if (st_ff == StSum) begin
         wneg_ff <= tsum[PW-1];
         if (tsum > PW'(AccMax)) t_ff <= AccMax;
         else if (tsum < PW'(AccMin)) t_ff <= AccMin;
         else t_ff <= tsum[AccWidth-1:0];
      end
      // low half product is ready; keep it with the rounding constant
      if (st_ff == StWgh) plo_ff <= 41'(prod_ff) + 41'd32768;
      // both halves ready: signed contribution
      if (st_ff == StCon) cont_ff <= wneg_ff ? -$signed(mag) : $signed(mag);
      if (st_ff == StOut && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.out_index <= job_ff.vertex_index;
         rsp_ff.out_x     <= sat[0];
         rsp_ff.out_y     <= sat[1];
         rsp_ff.out_z     <= sat[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/linear_blend_skinning.sv
// Linear blend skinning top level: front end, influence queue, back end, palette.
// The back end takes one queued influence at a time and, per column, runs palette
// reads and products through the shared 33x33 multiplier, then rounding, two weight
// half products, contribution and accumulation; a last influence's result waits while
// an earlier one is stalled. Palette writes wait while an influence is queued or in
// progress. Reset is synchronous, active high; the palette memory is not cleared.
module linear_blend_skinning
   import lbs_pkg::*;
#(
   parameter int unsigned NUM_BONES = 64,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned Words     = NUM_BONES * ElemsPerBone;
   localparam int unsigned AddrWidth = $clog2(Words);

   logic                 pal_we;
   logic [AddrWidth-1:0] pal_waddr, pal_raddr;
   logic signed [31:0]   pal_wdata, pal_rdata_ff;
   logic                 job_valid, job_take;
   logic                 back_busy;
   job_type              job_data;
   logic signed [31:0]   pal_mem [Words];

   // Palette memory, registered read
   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
      pal_rdata_ff <= pal_mem[pal_raddr];
   end

   lbs_front #(.NUM_BONES(NUM_BONES), .AddrWidth(AddrWidth)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data, .back_busy,
      .pal_we, .pal_waddr, .pal_wdata, .job_valid, .job_take, .job_data
   );

   lbs_back #(.FRAC_BITS(FRAC_BITS), .AddrWidth(AddrWidth)) u_back (
      .clock, .reset, .job_valid, .job_take, .job_data, .busy(back_busy),
      .pal_raddr, .pal_rdata(pal_rdata_ff), .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
